@@ rtl/core/ncic_pkg.sv @@
// ----------------------------------------------------------------------------
// ncic_pkg
// Shared types and codes of the nibble controller instruction core: opcodes,
// data-nibble selects, sequencer states and the arithmetic unit interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ncic_pkg;

  localparam int unsigned NIB_W = 4;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned STEP_CNT_W = 2;

  // Opcodes, high nibble of the instruction byte.
  localparam logic [3:0] OP_NOP0 = 4'd0;
  localparam logic [3:0] OP_SETPINS = 4'd1;
  localparam logic [3:0] OP_WAIT = 4'd2;
  localparam logic [3:0] OP_JMPBACK = 4'd3;
  localparam logic [3:0] OP_LOADA = 4'd4;
  localparam logic [3:0] OP_MOVFROMA = 4'd5;
  localparam logic [3:0] OP_MOVTOA = 4'd6;
  localparam logic [3:0] OP_ALU = 4'd7;
  localparam logic [3:0] OP_PAGE = 4'd8;
  localparam logic [3:0] OP_JMP = 4'd9;
  localparam logic [3:0] OP_LOOPC = 4'd10;
  localparam logic [3:0] OP_LOOPD = 4'd11;
  localparam logic [3:0] OP_SKIP = 4'd12;
  localparam logic [3:0] OP_CALL = 4'd13;
  localparam logic [3:0] OP_RET = 4'd14;

  // Data-nibble selects of the move opcodes.
  localparam logic [3:0] SEL_B = 4'd1;
  localparam logic [3:0] SEL_C = 4'd2;
  localparam logic [3:0] SEL_D = 4'd3;
  localparam logic [3:0] SEL_ALLPINS = 4'd4;
  localparam logic [3:0] SEL_PIN0 = 4'd5;
  localparam logic [3:0] SEL_PIN1 = 4'd6;
  localparam logic [3:0] SEL_PIN2 = 4'd7;
  localparam logic [3:0] SEL_PIN3 = 4'd8;
  localparam logic [3:0] SEL_PWM = 4'd9;
  localparam logic [3:0] SEL_SERVO = 4'd10;
  localparam logic [3:0] SEL_ADC = 4'd9;

  // ALU selects.
  localparam logic [3:0] ALU_INC = 4'd1;
  localparam logic [3:0] ALU_DEC = 4'd2;
  localparam logic [3:0] ALU_ADD = 4'd3;
  localparam logic [3:0] ALU_SUB = 4'd4;
  localparam logic [3:0] ALU_MUL = 4'd5;
  localparam logic [3:0] ALU_DIV = 4'd6;
  localparam logic [3:0] ALU_AND = 4'd7;
  localparam logic [3:0] ALU_OR = 4'd8;
  localparam logic [3:0] ALU_XOR = 4'd9;
  localparam logic [3:0] ALU_NOT = 4'd10;

  // Skip conditions.
  localparam logic [3:0] SKP_GT = 4'd1;
  localparam logic [3:0] SKP_LT = 4'd2;
  localparam logic [3:0] SKP_EQ = 4'd3;
  localparam logic [3:0] SKP_IN0_HI = 4'd4;
  localparam logic [3:0] SKP_IN3_HI = 4'd7;
  localparam logic [3:0] SKP_IN0_LO = 4'd8;
  localparam logic [3:0] SKP_IN3_LO = 4'd11;
  localparam logic [3:0] SKP_S1_DN = 4'd12;
  localparam logic [3:0] SKP_S2_DN = 4'd13;
  localparam logic [3:0] SKP_S1_UP = 4'd14;
  localparam logic [3:0] SKP_S2_UP = 4'd15;

  localparam logic [3:0] NIB_ALL = 4'hf;

  // PWM request kinds.
  localparam logic [1:0] PWM_NONE = 2'd0;
  localparam logic [1:0] PWM_DUTY = 2'd1;
  localparam logic [1:0] PWM_SERVO = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/nibble_controller_instruction_core.sv @@
// Sequence: a plain instruction is captured, then committed in ST_EXEC and shown in
// ST_OUT; a multiply or divide waits in ST_ITER for the shared unit, one bit per cycle.
// A new instruction is taken only once the result has been delivered;
// in_tready is high only while the core is idle.
// Reset (rst_n low at a clock edge) clears A, B, C, D, page, program counter,
// return address and output pins, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// nibble_controller_instruction_core
// Executes one 8-bit instruction of a 4-bit programmable controller per input
// transfer and returns the next fetch address, the pins and any wait or PWM
// request as one output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_controller_instruction_core
  import ncic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // instr[7:0], din[11:8], switches[13:12], adc_level[17:14], zero above
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // fetch_addr[7:0], dout[11:8], wait_req[12], delay_code[16:13],
  // pwm_level[20:17], zero above
  output logic      [23:0] out_tdata,
  // pwm_mode[1:0]: what pwm_level is meant for
  output logic      [1:0]  out_tuser
);

  state_t state_r, state_nxt;

  // Instruction and pin levels captured at the input transfer.
  logic [7:0]       instr_r;
  logic [NIB_W-1:0] din_r;
  logic [1:0]       sw_r;
  logic [NIB_W-1:0] adc_r;

  // Architectural state.
  logic [NIB_W-1:0]  a_r, a_nxt;
  logic [NIB_W-1:0]  b_r, b_nxt;
  logic [NIB_W-1:0]  c_r, c_nxt;
  logic [NIB_W-1:0]  d_r, d_nxt;
  logic [NIB_W-1:0]  page_r, page_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [ADDR_W-1:0] ret_r, ret_nxt;
  logic [NIB_W-1:0]  pins_r, pins_nxt;

  // Result register, loaded when the instruction commits.
  logic [ADDR_W-1:0] res_addr_r;
  logic [NIB_W-1:0]  res_pins_r;
  logic              res_dly_r, dly_nxt;
  logic [NIB_W-1:0]  res_dcode_r, dcode_nxt;
  logic [1:0]        res_pmode_r, pmode_nxt;
  logic [NIB_W-1:0]  res_plevel_r, plevel_nxt;

  logic [3:0]        opc;
  logic [3:0]        dat;
  logic [ADDR_W-1:0] target;
  logic [ADDR_W-1:0] pc_inc;
  logic [NIB_W-1:0]  c_dec;
  logic [NIB_W-1:0]  d_dec;
  logic              needs_md;
  logic              commit;
  logic [NIB_W-1:0]  alu_res;
  logic              skip;
  logic [1:0]        pin_idx;
  md_ctrl_t          md_ctrl;
  md_stat_t          md_stat;
  logic [NIB_W-1:0]  md_res;

  assign opc    = instr_r[7:4];
  assign dat    = instr_r[3:0];
  assign target = {page_r, dat};
  assign pc_inc = pc_r + 1'b1;
  assign c_dec  = c_r - 1'b1;
  assign d_dec  = d_r - 1'b1;
  // Select values 5..8 address pins 0..3.
  assign pin_idx = dat[1:0] - 2'd1;
  assign needs_md = (opc == OP_ALU) && ((dat == ALU_MUL) || (dat == ALU_DIV));

  ncic_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (md_ctrl),
    .op_a   (a_r),
    .op_b   (b_r),
    .stat   (md_stat),
    .result (md_res)
  );

  // Sequencer: capture, run the shared unit when the ALU needs it, commit,
  // then hold the result until the output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    commit         = 1'b0;
    md_ctrl.start  = 1'b0;
    md_ctrl.is_div = (dat == ALU_DIV);
    in_tready      = 1'b0;
    out_tvalid     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (needs_md) begin
          md_ctrl.start = 1'b1;
          state_nxt     = ST_ITER;
        end else begin
          commit    = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_ITER: begin
        if (md_stat.done) begin
          commit    = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Nibble ALU; multiply and divide come from the shared iterative unit.
  always_comb begin
    unique case (dat)
      ALU_INC: alu_res = a_r + 1'b1;
      ALU_DEC: alu_res = a_r - 1'b1;
      ALU_ADD: alu_res = a_r + b_r;
      ALU_SUB: alu_res = a_r - b_r;
      ALU_MUL: alu_res = md_res;
      ALU_DIV: alu_res = md_res;
      ALU_AND: alu_res = a_r & b_r;
      ALU_OR:  alu_res = a_r | b_r;
      ALU_XOR: alu_res = a_r ^ b_r;
      ALU_NOT: alu_res = a_r ^ NIB_ALL;
      default: alu_res = a_r;
    endcase
  end

  // Skip conditions: compares of A with B, input pin levels and switches
  // (a switch reads 0 when pressed).
  always_comb begin
    if (dat == SKP_GT) begin
      skip = a_r > b_r;
    end else if (dat == SKP_LT) begin
      skip = a_r < b_r;
    end else if (dat == SKP_EQ) begin
      skip = a_r == b_r;
    end else if ((dat >= SKP_IN0_HI) && (dat <= SKP_IN3_HI)) begin
      skip = din_r[dat[1:0]];
    end else if ((dat >= SKP_IN0_LO) && (dat <= SKP_IN3_LO)) begin
      skip = !din_r[dat[1:0]];
    end else if (dat == SKP_S1_DN) begin
      skip = !sw_r[0];
    end else if (dat == SKP_S2_DN) begin
      skip = !sw_r[1];
    end else if (dat == SKP_S1_UP) begin
      skip = sw_r[0];
    end else if (dat == SKP_S2_UP) begin
      skip = sw_r[1];
    end else begin
      skip = 1'b0;
    end
  end

  // Instruction effect. The counter advances by one unless the opcode sets it;
  // jump back and skip count from the address of the instruction itself.
  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    page_nxt   = page_r;
    pc_nxt     = pc_inc;
    ret_nxt    = ret_r;
    pins_nxt   = pins_r;
    dly_nxt    = 1'b0;
    dcode_nxt  = '0;
    pmode_nxt  = PWM_NONE;
    plevel_nxt = '0;
    unique case (opc)
      OP_SETPINS: pins_nxt = dat;
      OP_WAIT: begin
        dly_nxt   = 1'b1;
        dcode_nxt = dat;
      end
      // Back by the data nibble from the instruction itself.
      OP_JMPBACK: pc_nxt = pc_r - {4'd0, dat};
      OP_LOADA: a_nxt = dat;
      OP_MOVFROMA: begin
        if (dat == SEL_B) begin
          b_nxt = a_r;
        end else if (dat == SEL_C) begin
          c_nxt = a_r;
        end else if (dat == SEL_D) begin
          d_nxt = a_r;
        end else if (dat == SEL_ALLPINS) begin
          pins_nxt = a_r;
        end else if ((dat >= SEL_PIN0) && (dat <= SEL_PIN3)) begin
          pins_nxt[pin_idx] = a_r[0];
        end else if (dat == SEL_PWM) begin
          pmode_nxt  = PWM_DUTY;
          plevel_nxt = a_r;
        end else if (dat == SEL_SERVO) begin
          pmode_nxt  = PWM_SERVO;
          plevel_nxt = a_r;
        end
      end
      OP_MOVTOA: begin
        if (dat == SEL_B) begin
          a_nxt = b_r;
        end else if (dat == SEL_C) begin
          a_nxt = c_r;
        end else if (dat == SEL_D) begin
          a_nxt = d_r;
        end else if (dat == SEL_ALLPINS) begin
          a_nxt = din_r;
        end else if ((dat >= SEL_PIN0) && (dat <= SEL_PIN3)) begin
          a_nxt = {3'd0, din_r[pin_idx]};
        end else if (dat == SEL_ADC) begin
          a_nxt = adc_r;
        end
      end
      OP_ALU:  a_nxt = alu_res;
      OP_PAGE: page_nxt = dat;
      OP_JMP:  pc_nxt = target;
      OP_LOOPC: begin
        c_nxt = c_dec;
        if (c_dec != '0) begin
          pc_nxt = target;
        end
      end
      OP_LOOPD: begin
        d_nxt = d_dec;
        if (d_dec != '0) begin
          pc_nxt = target;
        end
      end
      OP_SKIP: begin
        if (skip) begin
          pc_nxt = pc_r + 8'd2;
        end
      end
      // A single return address: each call overwrites it.
      OP_CALL: begin
        ret_nxt = pc_inc;
        pc_nxt  = target;
      end
      OP_RET: pc_nxt = ret_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r    <= '0;
      b_r    <= '0;
      c_r    <= '0;
      d_r    <= '0;
      page_r <= '0;
      pc_r   <= '0;
      ret_r  <= '0;
      pins_r <= '0;
    end else if (commit) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      d_r    <= d_nxt;
      page_r <= page_nxt;
      pc_r   <= pc_nxt;
      ret_r  <= ret_nxt;
      pins_r <= pins_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      instr_r <= in_tdata[7:0];
      din_r   <= in_tdata[11:8];
      sw_r    <= in_tdata[13:12];
      adc_r   <= in_tdata[17:14];
    end
    if (commit) begin
      res_addr_r   <= pc_nxt;
      res_pins_r   <= pins_nxt;
      res_dly_r    <= dly_nxt;
      res_dcode_r  <= dcode_nxt;
      res_pmode_r  <= pmode_nxt;
      res_plevel_r <= plevel_nxt;
    end
  end

  assign out_tdata = {3'd0, res_plevel_r, res_dcode_r, res_dly_r, res_pins_r, res_addr_r};
  assign out_tuser = res_pmode_r;

endmodule

`default_nettype wire

@@ rtl/core/ncic_muldiv.sv @@
// ----------------------------------------------------------------------------
// ncic_muldiv
// Iterative 4-bit multiply / divide unit. One bit per cycle: shift-and-add
// for the product (low nibble kept), restoring division for the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ncic_muldiv
  import ncic_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire md_ctrl_t         ctrl,
  input  wire logic [NIB_W-1:0] op_a,
  input  wire logic [NIB_W-1:0] op_b,
  output md_stat_t              stat,
  output logic      [NIB_W-1:0] result
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  div_r, div_nxt;
  logic [NIB_W-1:0]      x_r, x_nxt;
  logic [NIB_W-1:0]      y_r, y_nxt;
  logic [NIB_W-1:0]      acc_r, acc_nxt;
  logic [NIB_W:0]        trial;
  logic [NIB_W:0]        diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  // For division x holds the dividend, shifted out as quotient bits come in,
  // and acc holds the partial remainder. A zero divisor yields all ones.
  assign trial = {acc_r, x_r[NIB_W-1]};
  assign diff  = trial - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      div_nxt  = ctrl.is_div;
      x_nxt    = op_a;
      y_nxt    = op_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[NIB_W]) begin
          acc_nxt = diff[NIB_W-1:0];
          x_nxt   = {x_r[NIB_W-2:0], 1'b1};
        end else begin
          acc_nxt = trial[NIB_W-1:0];
          x_nxt   = {x_r[NIB_W-2:0], 1'b0};
        end
      end else begin
        acc_nxt = acc_r + (y_r[0] ? x_r : '0);
        x_nxt   = {x_r[NIB_W-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[NIB_W-1:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_CNT_W'(NIB_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = div_r ? x_r : acc_r;

endmodule

`default_nettype wire

@@ rtl/core/ncic_checker.sv @@
// ----------------------------------------------------------------------------
// ncic_checker
// Port-level checks of the instruction core: one instruction in flight at a
// time, one result per instruction, and consistent request fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ncic_checker
  import ncic_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // The core takes no new instruction while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // Right after an input transfer the core is busy, neither ready nor valid.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("core not busy after input transfer");

  // A delivered result is not followed at once by another.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid)
    else $error("more than one result for an instruction");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // Request fields stay zero when no request is made, and the PWM mode is a known kind.
  a_req_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser <= PWM_SERVO)
                    && (out_tdata[12] || (out_tdata[16:13] == 4'd0))
                    && ((out_tuser != PWM_NONE) || (out_tdata[20:17] == 4'd0))))
    else $error("inconsistent wait or PWM request fields");

endmodule

bind nibble_controller_instruction_core ncic_checker u_ncic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
